// ===== rtl/assert_macros.svh =====
// assertion macros shared by the compensation rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence a fixed number of cycles after the antecedent
`define ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

// ===== rtl/bptc_pkg.sv =====
// shared widths, register map and output limits for the compensation block
// no dependencies
package bptc_pkg;

   // port widths
   localparam int unsigned CAL_W  = 16;
   localparam int unsigned RAW_W  = 24;
   localparam int unsigned TEMP_W = 15;
   localparam int unsigned PRES_W = 17;
   localparam int unsigned CSR_AW = 5;
   localparam int unsigned CSR_DW = 32;

   // register stages from accepted word to result strobe
   localparam int PIPE_DEPTH = 13;

   // register index, byte address divided by four
   typedef enum logic [2:0] {
      REG_CAL_C1 = 3'd0,
      REG_CAL_C2 = 3'd1,
      REG_CAL_C3 = 3'd2,
      REG_CAL_C4 = 3'd3,
      REG_CAL_C5 = 3'd4,
      REG_CAL_C6 = 3'd5
   } reg_index_type;

   // temperature offsets applied to the truncated dT*c6 term
   localparam logic signed [18:0] TEMP_REF = 19'sd2000;
   localparam logic signed [18:0] VLO_REF  = 19'sd3500;

   // saturation limits
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
   localparam logic [PRES_W-1:0]        PRES_MIN = 17'd1000;
   localparam logic [PRES_W-1:0]        PRES_MAX = 17'd120000;

endpackage

// ===== rtl/baro_pressure_temp_compensation.sv =====
// barometric pressure and temperature compensation, 13-stage pipeline
// depends on bptc_pkg and assert_macros.svh
//
// One raw pressure/temperature word is taken on every clock at which start is high;
// busy never rises, so words may arrive back to back. Each word gives one result, shown
// for a single cycle with rsp_valid high, in the order taken. There is no back-pressure:
// the receiver must capture every strobe. The stages follow the dependent products
// (dT, then the squares of the temperature error, then the 24 by 40 bit pressure product
// done as two partial products plus a wide add) and the truncating shifts between them.
// The user must write calibration words through the APB-style port only while no word
// is in flight; the block does not enforce it. Reads return the stored words.
`include "assert_macros.svh"

module baro_pressure_temp_compensation (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [bptc_pkg::RAW_W-1:0]          req_raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]          req_raw_temp,
   // result channel
   output logic                                rsp_valid,
   output logic signed [bptc_pkg::TEMP_W-1:0]  rsp_temp_centi,
   output logic [bptc_pkg::PRES_W-1:0]         rsp_pressure_pa,
   output logic                                rsp_clamped,
   // calibration registers
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bptc_pkg::CSR_AW-1:0]         paddr,
   input  logic [bptc_pkg::CSR_DW-1:0]         pwdata,
   output logic [bptc_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import bptc_pkg::*;

   // calibration registers
   logic [CAL_W-1:0] cal_c1_ff, cal_c2_ff, cal_c3_ff, cal_c4_ff, cal_c5_ff, cal_c6_ff;
   logic [CAL_W-1:0] cal_c1_in, cal_c2_in, cal_c3_in, cal_c4_in, cal_c5_in, cal_c6_in;
   logic             csr_wr;
   reg_index_type    csr_index;

   // valid bits, one per stage
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic                  accept;

   // carried payload lines
   logic [RAW_W-1:0]   dp_line_ff [8];
   logic [RAW_W-1:0]   dp_line_in [8];
   logic signed [19:0] temp_line_ff [8];
   logic signed [19:0] temp_line_in [8];
   logic signed [35:0] off_line_ff [3];
   logic signed [35:0] off_line_in [3];
   logic signed [34:0] sens_line_ff [3];
   logic signed [34:0] sens_line_in [3];
   logic signed [39:0] offf_line_ff [3];
   logic signed [39:0] offf_line_in [3];

   // stage 1: dT
   logic signed [24:0] s1_dt_ff, s1_dt_in;
   // stage 2: first products
   logic signed [41:0] s2_mt_ff, s2_mt_in, s2_mo_ff, s2_mo_in, s2_ms_ff, s2_ms_in;
   logic [47:0]        s2_dsq_ff, s2_dsq_in;
   logic signed [49:0] dt_sq;
   // stage 3: truncating shifts
   logic signed [41:0] mt_bias, mo_bias, ms_bias;
   logic signed [18:0] s3_tq_ff, s3_tq_in;
   logic signed [34:0] s3_otr_ff, s3_otr_in;
   logic signed [33:0] s3_str_ff, s3_str_in;
   logic [16:0]        s3_t2_ff, s3_t2_in;
   // stage 4: first-order terms
   logic signed [18:0] s4_temp_ff, s4_temp_in, s4_a_ff, s4_a_in, s4_b_ff, s4_b_in;
   logic signed [35:0] s4_off_ff, s4_off_in;
   logic signed [34:0] s4_sens_ff, s4_sens_in;
   logic [16:0]        s4_t2_ff, s4_t2_in;
   // stage 5: squares of the temperature error
   logic signed [37:0] a_sq, b_sq;
   logic [34:0]        s5_sq_ff, s5_sq_in, s5_sq2_ff, s5_sq2_in;
   logic               s5_lo_ff, s5_lo_in, s5_vlo_ff, s5_vlo_in;
   // stage 6: scaled squares
   logic [36:0]        s6_m5_ff, s6_m5_in;
   logic [37:0]        s6_m7_ff, s6_m7_in;
   logic [38:0]        s6_m11_ff, s6_m11_in;
   // stage 7: second-order corrections
   logic [37:0]        s7_off2_ff, s7_off2_in, s7_sens2_ff, s7_sens2_in;
   // stage 8: corrected offset and sensitivity
   logic signed [39:0] s8_off_ff, s8_off_in, s8_sens_ff, s8_sens_in;
   // stage 9: partial products of the pressure product
   logic [43:0]        s9_pplo_ff, s9_pplo_in;
   logic signed [44:0] s9_pphi_ff, s9_pphi_in;
   // stage 10: full product
   logic signed [63:0] s10_prod_ff, s10_prod_in;
   // stage 11: product over 2^21
   logic signed [63:0] prod_bias;
   logic signed [42:0] s11_q_ff, s11_q_in;
   // stage 12: offset removed
   logic signed [43:0] s12_r_ff, s12_r_in;
   // stage 13: scaled, saturated result
   logic signed [43:0] r_bias;
   logic signed [28:0] pres_q;
   logic signed [19:0] temp_f;
   logic               temp_lo, temp_hi, pres_lo, pres_hi;
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [PRES_W-1:0]        rsp_pres_ff, rsp_pres_in;
   logic                     rsp_clamped_ff, rsp_clamped_in;
   // result range terms for the checks
   logic                     rsp_temp_ok, rsp_pres_ok, rsp_interior;

   // register port
   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_comb begin
      cal_c1_in = cal_c1_ff;
      cal_c2_in = cal_c2_ff;
      cal_c3_in = cal_c3_ff;
      cal_c4_in = cal_c4_ff;
      cal_c5_in = cal_c5_ff;
      cal_c6_in = cal_c6_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_CAL_C1: cal_c1_in = pwdata[CAL_W-1:0];
            REG_CAL_C2: cal_c2_in = pwdata[CAL_W-1:0];
            REG_CAL_C3: cal_c3_in = pwdata[CAL_W-1:0];
            REG_CAL_C4: cal_c4_in = pwdata[CAL_W-1:0];
            REG_CAL_C5: cal_c5_in = pwdata[CAL_W-1:0];
            REG_CAL_C6: cal_c6_in = pwdata[CAL_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_index)
         REG_CAL_C1: prdata = CSR_DW'(cal_c1_ff);
         REG_CAL_C2: prdata = CSR_DW'(cal_c2_ff);
         REG_CAL_C3: prdata = CSR_DW'(cal_c3_ff);
         REG_CAL_C4: prdata = CSR_DW'(cal_c4_ff);
         REG_CAL_C5: prdata = CSR_DW'(cal_c5_ff);
         REG_CAL_C6: prdata = CSR_DW'(cal_c6_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_c1_ff <= '0;
         cal_c2_ff <= '0;
         cal_c3_ff <= '0;
         cal_c4_ff <= '0;
         cal_c5_ff <= '0;
         cal_c6_ff <= '0;
      end else begin
         cal_c1_ff <= cal_c1_in;
         cal_c2_ff <= cal_c2_in;
         cal_c3_ff <= cal_c3_in;
         cal_c4_ff <= cal_c4_in;
         cal_c5_ff <= cal_c5_in;
         cal_c6_ff <= cal_c6_in;
      end
   end

   // handshake: a word enters on every start
   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: dT = D2 - c5*256
   assign s1_dt_in = $signed({1'b0, req_raw_temp}) - $signed({1'b0, cal_c5_ff, 8'b0});

   // stage 2: dT*c6, c4*dT, c3*dT, dT^2
   assign s2_mt_in  = s1_dt_ff * $signed({1'b0, cal_c6_ff});
   assign s2_mo_in  = s1_dt_ff * $signed({1'b0, cal_c4_ff});
   assign s2_ms_in  = s1_dt_ff * $signed({1'b0, cal_c3_ff});
   assign dt_sq     = s1_dt_ff * s1_dt_ff;
   assign s2_dsq_in = dt_sq[47:0];

   // stage 3: truncate toward zero by adding a bias on negative values
   assign mt_bias   = s2_mt_ff + 42'({23{s2_mt_ff[41]}});
   assign mo_bias   = s2_mo_ff + 42'({7{s2_mo_ff[41]}});
   assign ms_bias   = s2_ms_ff + 42'({8{s2_ms_ff[41]}});
   assign s3_tq_in  = mt_bias[41:23];
   assign s3_otr_in = mo_bias[41:7];
   assign s3_str_in = ms_bias[41:8];
   assign s3_t2_in  = s2_dsq_ff[47:31];

   // stage 4: TEMP, OFF, SENS; a = TEMP-2000, b = TEMP+1500
   assign s4_temp_in = s3_tq_ff + TEMP_REF;
   assign s4_a_in    = s3_tq_ff;
   assign s4_b_in    = s3_tq_ff + VLO_REF;
   assign s4_off_in  = 36'({cal_c2_ff, 16'b0}) + 36'(s3_otr_ff);
   assign s4_sens_in = 35'({cal_c1_ff, 15'b0}) + 35'(s3_str_ff);
   assign s4_t2_in   = s3_t2_ff;

   // stage 5: squares, low and very low temperature flags, TEMP - T2 when low
   assign a_sq      = s4_a_ff * s4_a_ff;
   assign b_sq      = s4_b_ff * s4_b_ff;
   assign s5_sq_in  = a_sq[34:0];
   assign s5_sq2_in = b_sq[34:0];
   assign s5_lo_in  = s4_a_ff[18];
   assign s5_vlo_in = s4_b_ff[18];

   // stage 6: 5*sq, 7*sq2, 11*sq2, zero outside their temperature band
   assign s6_m5_in  = s5_lo_ff  ? 37'(s5_sq_ff) * 37'd5 : '0;
   assign s6_m7_in  = s5_vlo_ff ? 38'(s5_sq2_ff) * 38'd7 : '0;
   assign s6_m11_in = s5_vlo_ff ? 39'(s5_sq2_ff) * 39'd11 : '0;

   // stage 7: OFF2 and SENS2
   assign s7_off2_in  = 38'(s6_m5_ff[36:1]) + s6_m7_ff;
   assign s7_sens2_in = 38'(s6_m5_ff[36:2]) + 38'(s6_m11_ff[38:1]);

   // stage 8: corrected OFF and SENS
   assign s8_off_in  = 40'(off_line_ff[2]) - 40'(s7_off2_ff);
   assign s8_sens_in = 40'(sens_line_ff[2]) - 40'(s7_sens2_ff);

   // stage 9: D1*SENS split at bit 20 of SENS
   assign s9_pplo_in = 44'(dp_line_ff[7]) * 44'(s8_sens_ff[19:0]);
   assign s9_pphi_in = $signed({1'b0, dp_line_ff[7]}) * $signed(s8_sens_ff[39:20]);

   // stage 10: recombine the partial products
   assign s10_prod_in = (64'(s9_pphi_ff) <<< 20) + 64'(s9_pplo_ff);

   // stage 11: truncating divide by 2^21
   assign prod_bias = s10_prod_ff + 64'({21{s10_prod_ff[63]}});
   assign s11_q_in  = prod_bias[63:21];

   // stage 12: subtract OFF
   assign s12_r_in = 44'(s11_q_ff) - 44'(offf_line_ff[2]);

   // stage 13: truncating divide by 2^15, saturate both results
   assign r_bias  = s12_r_ff + 44'({15{s12_r_ff[43]}});
   assign pres_q  = r_bias[43:15];
   assign temp_f  = temp_line_ff[7];
   assign temp_lo = temp_f < 20'(TEMP_MIN);
   assign temp_hi = temp_f > 20'(TEMP_MAX);
   assign pres_lo = pres_q < $signed(29'(PRES_MIN));
   assign pres_hi = pres_q > $signed(29'(PRES_MAX));

   always_comb begin
      priority if (temp_lo) begin
         rsp_temp_in = TEMP_MIN;
      end else if (temp_hi) begin
         rsp_temp_in = TEMP_MAX;
      end else begin
         rsp_temp_in = temp_f[TEMP_W-1:0];
      end
      priority if (pres_lo) begin
         rsp_pres_in = PRES_MIN;
      end else if (pres_hi) begin
         rsp_pres_in = PRES_MAX;
      end else begin
         rsp_pres_in = pres_q[PRES_W-1:0];
      end
      rsp_clamped_in = temp_lo | temp_hi | pres_lo | pres_hi;
   end

   // carried payload lines; T2 only counts below 2000
   always_comb begin
      dp_line_in[0]   = req_raw_pressure;
      temp_line_in[0] = 20'(s4_temp_ff) - (s4_a_ff[18] ? 20'(s4_t2_ff) : 20'd0);
      off_line_in[0]  = s4_off_ff;
      sens_line_in[0] = s4_sens_ff;
      offf_line_in[0] = s8_off_ff;
      for (int i = 1; i < 8; i++) begin
         dp_line_in[i]   = dp_line_ff[i-1];
         temp_line_in[i] = temp_line_ff[i-1];
      end
      for (int i = 1; i < 3; i++) begin
         off_line_in[i]  = off_line_ff[i-1];
         sens_line_in[i] = sens_line_ff[i-1];
         offf_line_in[i] = offf_line_ff[i-1];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_dt_ff       <= s1_dt_in;
      s2_mt_ff       <= s2_mt_in;
      s2_mo_ff       <= s2_mo_in;
      s2_ms_ff       <= s2_ms_in;
      s2_dsq_ff      <= s2_dsq_in;
      s3_tq_ff       <= s3_tq_in;
      s3_otr_ff      <= s3_otr_in;
      s3_str_ff      <= s3_str_in;
      s3_t2_ff       <= s3_t2_in;
      s4_temp_ff     <= s4_temp_in;
      s4_a_ff        <= s4_a_in;
      s4_b_ff        <= s4_b_in;
      s4_off_ff      <= s4_off_in;
      s4_sens_ff     <= s4_sens_in;
      s4_t2_ff       <= s4_t2_in;
      s5_sq_ff       <= s5_sq_in;
      s5_sq2_ff      <= s5_sq2_in;
      s5_lo_ff       <= s5_lo_in;
      s5_vlo_ff      <= s5_vlo_in;
      s6_m5_ff       <= s6_m5_in;
      s6_m7_ff       <= s6_m7_in;
      s6_m11_ff      <= s6_m11_in;
      s7_off2_ff     <= s7_off2_in;
      s7_sens2_ff    <= s7_sens2_in;
      s8_off_ff      <= s8_off_in;
      s8_sens_ff     <= s8_sens_in;
      s9_pplo_ff     <= s9_pplo_in;
      s9_pphi_ff     <= s9_pphi_in;
      s10_prod_ff    <= s10_prod_in;
      s11_q_ff       <= s11_q_in;
      s12_r_ff       <= s12_r_in;
      rsp_temp_ff    <= rsp_temp_in;
      rsp_pres_ff    <= rsp_pres_in;
      rsp_clamped_ff <= rsp_clamped_in;
      dp_line_ff     <= dp_line_in;
      temp_line_ff   <= temp_line_in;
      off_line_ff    <= off_line_in;
      sens_line_ff   <= sens_line_in;
      offf_line_ff   <= offf_line_in;
   end

   // result ports
   assign rsp_valid       = valid_ff[PIPE_DEPTH-1];
   assign rsp_temp_centi  = rsp_temp_ff;
   assign rsp_pressure_pa = rsp_pres_ff;
   assign rsp_clamped     = rsp_clamped_ff;

   // range terms of the word on the result ports
   assign rsp_temp_ok  = (rsp_temp_centi >= TEMP_MIN) && (rsp_temp_centi <= TEMP_MAX);
   assign rsp_pres_ok  = (rsp_pressure_pa >= PRES_MIN) && (rsp_pressure_pa <= PRES_MAX);
   assign rsp_interior = rsp_valid
                         && (rsp_temp_centi > TEMP_MIN) && (rsp_temp_centi < TEMP_MAX)
                         && (rsp_pressure_pa > PRES_MIN) && (rsp_pressure_pa < PRES_MAX);

   // checks
   `ASSERT_AFTER(a_latency, clock, reset, accept, PIPE_DEPTH, rsp_valid, "word lost in pipeline")
   `ASSERT_IMPLIES(a_temp_range, clock, reset, rsp_valid, rsp_temp_ok, "temperature out of range")
   `ASSERT_IMPLIES(a_pres_range, clock, reset, rsp_valid, rsp_pres_ok, "pressure out of range")
   `ASSERT_IMPLIES(a_clamp_flag, clock, reset, rsp_interior, !rsp_clamped, "spurious clamp flag")

endmodule
